// ===== hw/rtl/md5_pkg.sv =====
// Shared types, constants and round tables of the MD5 digest unit.
`default_nettype none

package md5_pkg;

   localparam int unsigned WORD_DEPTH = 16;
   localparam int unsigned WORD_AW    = 4;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_ROUND = 7'b0001000,
      ST_FINAL = 7'b0010000,
      ST_OUT0  = 7'b0100000,
      ST_OUT1  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA = 2'd0,
      SEL_PAD  = 2'd1,
      SEL_ZERO = 2'd2,
      SEL_LEN  = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic         push;
      byte_sel_type byte_sel;
      logic         latch_len;
      logic         init;
      logic         start;
      logic         round_en;
      logic         final_add;
      logic         out_half;
      logic [5:0]   round;
      logic [5:0]   rd_round;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] pos;
   } dp_status_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

   function automatic logic [4:0] rot_amt(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:    s = 5'd7;
         4'd1:    s = 5'd12;
         4'd2:    s = 5'd17;
         4'd3:    s = 5'd22;
         4'd4:    s = 5'd5;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd14;
         4'd7:    s = 5'd20;
         4'd8:    s = 5'd4;
         4'd9:    s = 5'd11;
         4'd10:   s = 5'd16;
         4'd11:   s = 5'd23;
         4'd12:   s = 5'd6;
         4'd13:   s = 5'd10;
         4'd14:   s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [WORD_AW-1:0] msg_index(input logic [5:0] r);
      logic [WORD_AW-1:0] r4;
      logic [WORD_AW-1:0] idx;
      r4 = r[WORD_AW-1:0];
      case (r[5:4])
         2'd0:    idx = r4;
         2'd1:    idx = r4 * 4'd5 + 4'd1;
         2'd2:    idx = r4 * 4'd3 + 4'd5;
         default: idx = r4 * 4'd7;
      endcase
      return idx;
   endfunction

   function automatic logic [31:0] sine_const(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/md5_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none

module md5_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/md5_dpath.sv =====
// MD5 datapath: byte packing, bit count, block word RAM, round logic and chain words.
`default_nettype none

module md5_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire md5_pkg::dp_cmd_type   cmd,
   input  wire logic [7:0]            data_byte,
   output md5_pkg::dp_status_type     status,
   output logic [63:0]                digest_half
);

   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic [23:0] word_ff, word_in;
   logic [31:0] h0_ff, h1_ff, h2_ff, h3_ff;
   logic [31:0] h0_in, h1_in, h2_in, h3_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [5:0]  pos;
   logic [7:0]  push_byte;
   logic        wr_en;
   logic [31:0] wr_data;
   logic [31:0] w_word;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [31:0] new_b;

   assign pos = count_ff[8:3];
   assign status.pos = pos;

   always_comb begin
      case (cmd.byte_sel)
         md5_pkg::SEL_DATA: push_byte = data_byte;
         md5_pkg::SEL_PAD:  push_byte = md5_pkg::PAD_BYTE;
         md5_pkg::SEL_LEN:  push_byte = len_ff[{pos[2:0], 3'b000} +: 8];
         default:           push_byte = 8'h00;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      word_in  = word_ff;
      if (cmd.init) begin
         count_in = 64'd0;
      end else if (cmd.push) begin
         count_in = count_ff + 64'd8;
         case (pos[1:0])
            2'd0:    word_in[7:0]   = push_byte;
            2'd1:    word_in[15:8]  = push_byte;
            2'd2:    word_in[23:16] = push_byte;
            default: word_in        = word_ff;
         endcase
      end
      len_in = cmd.latch_len ? count_in : len_ff;
   end

   assign wr_en   = cmd.push && (pos[1:0] == 2'b11);
   assign wr_data = {push_byte, word_ff};

   md5_ram #(
      .WIDTH (32),
      .DEPTH (md5_pkg::WORD_DEPTH)
   ) u_words (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos[5:2]),
      .wr_data (wr_data),
      .rd_addr (md5_pkg::msg_index(cmd.rd_round)),
      .rd_data (w_word)
   );

   always_comb begin
      case (cmd.round[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum   = a_ff + f_val + md5_pkg::sine_const(cmd.round) + w_word;
      new_b = b_ff + md5_pkg::rotl(sum, md5_pkg::rot_amt(cmd.round));
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.start) begin
         a_in = h0_ff;
         b_in = h1_ff;
         c_in = h2_ff;
         d_in = h3_ff;
      end else if (cmd.round_en) begin
         a_in = d_ff;
         b_in = new_b;
         c_in = b_ff;
         d_in = c_ff;
      end
   end

   always_comb begin
      h0_in = h0_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      h3_in = h3_ff;
      if (cmd.init) begin
         h0_in = md5_pkg::INIT_A;
         h1_in = md5_pkg::INIT_B;
         h2_in = md5_pkg::INIT_C;
         h3_in = md5_pkg::INIT_D;
      end else if (cmd.final_add) begin
         h0_in = h0_ff + a_ff;
         h1_in = h1_ff + b_ff;
         h2_in = h2_ff + c_ff;
         h3_in = h3_ff + d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 64'd0;
         h0_ff    <= md5_pkg::INIT_A;
         h1_ff    <= md5_pkg::INIT_B;
         h2_ff    <= md5_pkg::INIT_C;
         h3_ff    <= md5_pkg::INIT_D;
      end else begin
         count_ff <= count_in;
         h0_ff    <= h0_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
         h3_ff    <= h3_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      word_ff <= word_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
   end

   assign digest_half = cmd.out_half ? {h3_ff, h2_ff} : {h1_ff, h0_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/md5_ctrl.sv =====
// MD5 controller: input handshake, padding sequence, round counter and digest output.
`default_nettype none

module md5_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_byte_present,
   input  wire logic                  req_end_of_message,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_half_index,
   output logic                       rsp_last_of_run,
   input  wire md5_pkg::dp_status_type status,
   output md5_pkg::dp_cmd_type        cmd
);

   md5_pkg::state_type state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       pad_ff, pad_in;
   logic       first_ff, first_in;
   logic       lenph_ff, lenph_in;
   logic       done_ff, done_in;
   logic       in_len;

   assign in_len = lenph_ff || (!first_ff && (status.pos == md5_pkg::LEN_POS));

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      pad_in    = pad_ff;
      first_in  = first_ff;
      lenph_in  = lenph_ff;
      done_in   = done_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_half_index  = 1'b0;
      rsp_last_of_run = 1'b0;
      cmd = '0;
      cmd.byte_sel = md5_pkg::SEL_DATA;
      cmd.round    = round_ff;
      cmd.rd_round = round_ff + 6'd1;

      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push      = req_byte_present;
               cmd.latch_len = req_end_of_message;
               pad_in   = req_end_of_message;
               first_in = req_end_of_message;
               lenph_in = 1'b0;
               if (req_byte_present && (status.pos == md5_pkg::LAST_POS)) begin
                  state_in = md5_pkg::ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            cmd.push = 1'b1;
            if (first_ff) begin
               cmd.byte_sel = md5_pkg::SEL_PAD;
            end else if (in_len) begin
               cmd.byte_sel = md5_pkg::SEL_LEN;
            end else begin
               cmd.byte_sel = md5_pkg::SEL_ZERO;
            end
            first_in = 1'b0;
            lenph_in = in_len;
            if (status.pos == md5_pkg::LAST_POS) begin
               done_in  = in_len;
               state_in = md5_pkg::ST_LOAD;
            end
         end
         md5_pkg::ST_LOAD: begin
            cmd.start    = 1'b1;
            cmd.rd_round = 6'd0;
            round_in     = 6'd0;
            state_in     = md5_pkg::ST_ROUND;
         end
         md5_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = md5_pkg::ST_FINAL;
            end
         end
         md5_pkg::ST_FINAL: begin
            cmd.final_add = 1'b1;
            if (done_ff) begin
               state_in = md5_pkg::ST_OUT0;
            end else if (pad_ff) begin
               state_in = md5_pkg::ST_PAD;
            end else begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         md5_pkg::ST_OUT0: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = md5_pkg::ST_OUT1;
            end
         end
         md5_pkg::ST_OUT1: begin
            rsp_valid       = 1'b1;
            rsp_half_index  = 1'b1;
            rsp_last_of_run = 1'b1;
            cmd.out_half    = 1'b1;
            if (rsp_ready) begin
               cmd.init = 1'b1;
               pad_in   = 1'b0;
               done_in  = 1'b0;
               state_in = md5_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         round_ff <= 6'd0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         lenph_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         lenph_ff <= lenph_in;
         done_ff  <= done_in;
      end
   end

   // digest is never shown while bytes are still being taken
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result shown while accepting items");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::ST_ROUND && round_ff == md5_pkg::LAST_ROUND)
      |=> (state_ff == md5_pkg::ST_FINAL))
      else $error("compression did not finish after last round");

   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && status.pos == md5_pkg::LAST_POS) |=> (state_ff == md5_pkg::ST_LOAD))
      else $error("full block not compressed");

   a_done_pad: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> pad_ff)
      else $error("digest ready outside of padding");

   a_half_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::ST_OUT0 && rsp_ready) |=> (state_ff == md5_pkg::ST_OUT1))
      else $error("second digest half skipped");

endmodule

`default_nettype wire

// ===== hw/rtl/md5_message_digest_unit.sv =====
// MD5 message digest unit: one byte per item, digest out as two 64-bit halves.
// Byte items are taken while idle; the byte that fills a 64-byte block holds off input
// for a word fetch, 64 rounds of the shared round unit and one chain add.
// An end item adds 9 to 72 padding bytes plus one or two block compressions,
// then the two digest halves are shown in order, each held until taken.
// Synchronous reset restores the initial chain words and a zero bit count.
`default_nettype none

module md5_message_digest_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_half,
   output logic             rsp_half_index,
   output logic             rsp_last_of_run
);

   md5_pkg::dp_cmd_type    cmd;
   md5_pkg::dp_status_type status;

   md5_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_half_index     (rsp_half_index),
      .rsp_last_of_run    (rsp_last_of_run),
      .status             (status),
      .cmd                (cmd)
   );

   md5_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_half (rsp_digest_half)
   );

endmodule

`default_nettype wire
